// ===== src/tun_pkg.sv =====
// Shared widths, constants and payload types of the triangle unit normal block.
package tun_pkg;

  localparam int CoordBits = 16;
  localparam int EdgeBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * EdgeBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int MagBits   = ProdBits;
  localparam int SmallBits = 16;
  localparam int NormBits  = 31;
  localparam int SqBits    = 2 * NormBits;
  localparam int SumBits   = 64;
  localparam int RootBits  = 32;
  localparam int SqrtSteps = 32;
  localparam int FracBits  = 14;
  localparam int QuoBits   = FracBits + 1;
  localparam int NumBits   = NormBits + FracBits + 1;
  localparam int OutBits   = 16;
  localparam int LenBits   = 16;
  localparam int ShiftBits = 6;

  localparam logic [LenBits-1:0] MinLengthReset = LenBits'(7);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [OutBits-1:0]   comp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    logic [2:0]               neg;
    logic [2:0][MagBits-1:0]  mag;
  } cross_t;

  typedef struct packed {
    logic                     degen;
    logic [2:0]               neg;
    logic [2:0][NormBits-1:0] v;
  } side_t;

  typedef struct packed {
    logic  degen;
    comp_t x;
    comp_t y;
    comp_t z;
  } res_t;

endpackage

// ===== src/tun_cross.sv =====
// Edge vectors, partial products and cross product magnitudes in three stages.
module tun_cross (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tun_pkg::vtx_t va_i,
  input  tun_pkg::vtx_t vb_i,
  input  tun_pkg::vtx_t vc_i,
  output logic          valid_o,
  output tun_pkg::cross_t cross_o
);
  import tun_pkg::*;

  coord_t a [3];
  coord_t b [3];
  coord_t c [3];
  logic signed [EdgeBits-1:0]  e1_d [3];
  logic signed [EdgeBits-1:0]  e2_d [3];
  logic signed [EdgeBits-1:0]  e1_q [3];
  logic signed [EdgeBits-1:0]  e2_q [3];
  logic signed [ProdBits-1:0]  p_d [6];
  logic signed [ProdBits-1:0]  p_q [6];
  logic signed [CrossBits-1:0] cr [3];
  cross_t cross_d, cross_q;
  logic [2:0] v_q;

  assign a[0] = va_i.x;
  assign a[1] = va_i.y;
  assign a[2] = va_i.z;
  assign b[0] = vb_i.x;
  assign b[1] = vb_i.y;
  assign b[2] = vb_i.z;
  assign c[0] = vc_i.x;
  assign c[1] = vc_i.y;
  assign c[2] = vc_i.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = EdgeBits'(b[i]) - EdgeBits'(a[i]);
      e2_d[i] = EdgeBits'(c[i]) - EdgeBits'(a[i]);
    end
  end

  always_comb begin
    p_d[0] = ProdBits'(e1_q[1]) * ProdBits'(e2_q[2]);
    p_d[1] = ProdBits'(e1_q[2]) * ProdBits'(e2_q[1]);
    p_d[2] = ProdBits'(e1_q[2]) * ProdBits'(e2_q[0]);
    p_d[3] = ProdBits'(e1_q[0]) * ProdBits'(e2_q[2]);
    p_d[4] = ProdBits'(e1_q[0]) * ProdBits'(e2_q[1]);
    p_d[5] = ProdBits'(e1_q[1]) * ProdBits'(e2_q[0]);
  end

  always_comb begin
    cr[0] = CrossBits'(p_q[0]) - CrossBits'(p_q[1]);
    cr[1] = CrossBits'(p_q[2]) - CrossBits'(p_q[3]);
    cr[2] = CrossBits'(p_q[4]) - CrossBits'(p_q[5]);
    for (int i = 0; i < 3; i++) begin
      cross_d.neg[i] = cr[i][CrossBits-1];
      cross_d.mag[i] = cr[i][CrossBits-1] ? MagBits'(-cr[i]) : MagBits'(cr[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= e1_d[i];
        e2_q[i] <= e2_d[i];
      end
      for (int i = 0; i < 6; i++) begin
        p_q[i] <= p_d[i];
      end
      cross_q <= cross_d;
    end
  end

  assign valid_o = v_q[2];
  assign cross_o = cross_q;

endmodule

// ===== src/tun_norm.sv =====
// Degenerate test, normalizing shift and sum of squares in five stages.
module tun_norm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  tun_pkg::cross_t             cross_i,
  input  logic [tun_pkg::LenBits-1:0] min_len_i,
  output logic                        valid_o,
  output tun_pkg::side_t              side_o,
  output logic [tun_pkg::SumBits-1:0] sum_o
);
  import tun_pkg::*;

  localparam int SsBits = 2 * SmallBits + 2;
  localparam logic [ShiftBits-1:0] TopBit = ShiftBits'(NormBits - 1);

  logic [4:0] v_q;

  logic [MagBits-1:0]     m1_d, m1_q;
  logic                   small1_d, small1_q;
  logic [2*SmallBits-1:0] sqs1_d [3];
  logic [2*SmallBits-1:0] sqs1_q [3];
  cross_t                 x1_q;

  logic [SsBits-1:0]      ssum;
  logic [2*LenBits-1:0]   thr;
  logic [ShiftBits-1:0]   msb;
  logic [ShiftBits-1:0]   rs2_d, rs2_q, ls2_d, ls2_q;
  logic                   degen2_d, degen2_q;
  cross_t                 x2_q;

  side_t                  side3_d, side3_q, side4_q, side5_q;
  logic [SqBits-1:0]      sq4_d [3];
  logic [SqBits-1:0]      sq4_q [3];
  logic [SumBits-1:0]     sum5_d, sum5_q;

  always_comb begin
    m1_d = cross_i.mag[0];
    if (cross_i.mag[1] > m1_d) begin
      m1_d = cross_i.mag[1];
    end
    if (cross_i.mag[2] > m1_d) begin
      m1_d = cross_i.mag[2];
    end
    small1_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (|cross_i.mag[i][MagBits-1:SmallBits]) begin
        small1_d = 1'b0;
      end
      sqs1_d[i] = (2*SmallBits)'(cross_i.mag[i][SmallBits-1:0])
                * (2*SmallBits)'(cross_i.mag[i][SmallBits-1:0]);
    end
  end

  always_comb begin
    ssum = SsBits'(sqs1_q[0]) + SsBits'(sqs1_q[1]) + SsBits'(sqs1_q[2]);
    thr  = (2*LenBits)'(min_len_i) * (2*LenBits)'(min_len_i);
    degen2_d = (m1_q == '0) || (small1_q && (ssum < SsBits'(thr)));
    msb = '0;
    for (int k = 0; k < MagBits; k++) begin
      if (m1_q[k]) begin
        msb = ShiftBits'(k);
      end
    end
    if (msb > TopBit) begin
      rs2_d = msb - TopBit;
      ls2_d = '0;
    end else begin
      rs2_d = '0;
      ls2_d = TopBit - msb;
    end
  end

  always_comb begin
    side3_d.degen = degen2_q;
    side3_d.neg   = x2_q.neg;
    for (int i = 0; i < 3; i++) begin
      side3_d.v[i] = NormBits'((x2_q.mag[i] >> rs2_q) << ls2_q);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_d[i] = SqBits'(side3_q.v[i]) * SqBits'(side3_q.v[i]);
    end
    sum5_d = SumBits'(sq4_q[0]) + SumBits'(sq4_q[1]) + SumBits'(sq4_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q     <= m1_d;
      small1_q <= small1_d;
      x1_q     <= cross_i;
      for (int i = 0; i < 3; i++) begin
        sqs1_q[i] <= sqs1_d[i];
        sq4_q[i]  <= sq4_d[i];
      end
      degen2_q <= degen2_d;
      rs2_q    <= rs2_d;
      ls2_q    <= ls2_d;
      x2_q     <= x1_q;
      side3_q  <= side3_d;
      side4_q  <= side3_q;
      side5_q  <= side4_q;
      sum5_q   <= sum5_d;
    end
  end

  assign valid_o = v_q[4];
  assign side_o  = side5_q;
  assign sum_o   = sum5_q;

endmodule

// ===== src/tun_sqrt.sv =====
// Integer square root pipeline, one root bit per stage.
module tun_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  tun_pkg::side_t               side_i,
  input  logic [tun_pkg::SumBits-1:0]  rad_i,
  output logic                         valid_o,
  output tun_pkg::side_t               side_o,
  output logic [tun_pkg::RootBits-1:0] root_o
);
  import tun_pkg::*;

  logic               v_q    [SqrtSteps];
  logic [SumBits-1:0] rem_q  [SqrtSteps];
  logic [SumBits-1:0] root_q [SqrtSteps];
  side_t              side_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [SumBits-1:0] Bit = SumBits'(1) << (SumBits - 2 - 2 * k);

    logic               v_in;
    logic [SumBits-1:0] rem_in, root_in, trial;
    side_t              side_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = root_in + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= (root_in >> 1) + Bit;
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[SqrtSteps-1];
  assign side_o  = side_q[SqrtSteps-1];
  assign root_o  = root_q[SqrtSteps-1][RootBits-1:0];

endmodule

// ===== src/tun_div.sv =====
// Rounded division of the three lanes by the length, one quotient bit per stage.
module tun_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  tun_pkg::side_t               side_i,
  input  logic [tun_pkg::RootBits-1:0] root_i,
  output logic                         valid_o,
  output tun_pkg::res_t                res_o
);
  import tun_pkg::*;

  logic                vld0_q;
  logic [NumBits-1:0]  num0_d [3];
  logic [NumBits-1:0]  num0_q [3];
  logic [RootBits-1:0] len0_q;
  logic [3:0]          flg0_q;

  logic                vld_q [QuoBits];
  logic [NumBits-1:0]  rem_q [QuoBits][3];
  logic [QuoBits-1:0]  quo_q [QuoBits][3];
  logic [RootBits-1:0] len_q [QuoBits];
  logic [3:0]          flg_q [QuoBits];

  logic                vldf_q;
  comp_t               nrm_d [3];
  res_t                res_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num0_d[i] = (NumBits'(side_i.v[i]) << FracBits) + NumBits'(root_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        num0_q[i] <= num0_d[i];
      end
      len0_q <= root_i;
      flg0_q <= {side_i.degen, side_i.neg};
    end
  end

  for (genvar k = 0; k < QuoBits; k++) begin : g_step
    localparam int Sh = QuoBits - 1 - k;

    logic                v_in;
    logic [NumBits-1:0]  rem_in [3];
    logic [QuoBits-1:0]  quo_in [3];
    logic [RootBits-1:0] len_in;
    logic [3:0]          flg_in;
    logic [NumBits:0]    dv;

    if (k == 0) begin : g_first
      always_comb begin
        v_in   = vld0_q;
        len_in = len0_q;
        flg_in = flg0_q;
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = num0_q[i];
          quo_in[i] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_in   = vld_q[k-1];
        len_in = len_q[k-1];
        flg_in = flg_q[k-1];
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = rem_q[k-1][i];
          quo_in[i] = quo_q[k-1][i];
        end
      end
    end

    assign dv = (NumBits+1)'(len_in) << Sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k] <= len_in;
        flg_q[k] <= flg_in;
        for (int i = 0; i < 3; i++) begin
          if ((NumBits+1)'(rem_in[i]) >= dv) begin
            rem_q[k][i] <= NumBits'((NumBits+1)'(rem_in[i]) - dv);
            quo_q[k][i] <= quo_in[i] | (QuoBits'(1) << Sh);
          end else begin
            rem_q[k][i] <= rem_in[i];
            quo_q[k][i] <= quo_in[i];
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (flg_q[QuoBits-1][3]) begin
        nrm_d[i] = '0;
      end else if (flg_q[QuoBits-1][i]) begin
        nrm_d[i] = OutBits'(0) - OutBits'(quo_q[QuoBits-1][i]);
      end else begin
        nrm_d[i] = OutBits'(quo_q[QuoBits-1][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
    end else if (en_i) begin
      vldf_q <= vld_q[QuoBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.degen <= flg_q[QuoBits-1][3];
      res_q.x     <= nrm_d[0];
      res_q.y     <= nrm_d[1];
      res_q.z     <= nrm_d[2];
    end
  end

  assign valid_o = vldf_q;
  assign res_o   = res_q;

endmodule

// ===== src/triangle_unit_normal_unit.sv =====
// Top level of the triangle unit normal pipeline with output register and skid stage.
// Stages in order: cross, norm, square root, divider, then the output register.
// Throughput: one transaction per cycle while in_ready_o is high; depth is set by the
// 32-stage square root and the 15-stage divider lanes.
// Reset clears all valid bits and sets min_length to 7; payload registers are not reset.
// A stall freezes the pipeline only after the skid stage fills.
module triangle_unit_normal_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tun_pkg::coord_t             vertex_a_x_i,
  input  tun_pkg::coord_t             vertex_a_y_i,
  input  tun_pkg::coord_t             vertex_a_z_i,
  input  tun_pkg::coord_t             vertex_b_x_i,
  input  tun_pkg::coord_t             vertex_b_y_i,
  input  tun_pkg::coord_t             vertex_b_z_i,
  input  tun_pkg::coord_t             vertex_c_x_i,
  input  tun_pkg::coord_t             vertex_c_y_i,
  input  tun_pkg::coord_t             vertex_c_z_i,
  input  logic                        cfg_we_i,
  input  logic [tun_pkg::LenBits-1:0] cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tun_pkg::comp_t              normal_x_o,
  output tun_pkg::comp_t              normal_y_o,
  output tun_pkg::comp_t              normal_z_o,
  output logic                        degenerate_o
);
  import tun_pkg::*;

  localparam comp_t UnitMax = comp_t'(1 << FracBits);

  logic [LenBits-1:0] min_len_q;
  logic               en;
  vtx_t               va, vb, vc;

  logic               cr_v;
  cross_t             cr;
  logic               nm_v;
  side_t              nm_side;
  logic [SumBits-1:0] nm_sum;
  logic               sq_v;
  side_t              sq_side;
  logic [RootBits-1:0] sq_root;
  logic               tail_v;
  res_t               tail_res;
  logic               consume;

  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;

  assign va = '{x: vertex_a_x_i, y: vertex_a_y_i, z: vertex_a_z_i};
  assign vb = '{x: vertex_b_x_i, y: vertex_b_y_i, z: vertex_b_z_i};
  assign vc = '{x: vertex_c_x_i, y: vertex_c_y_i, z: vertex_c_z_i};

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign consume    = en && tail_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLengthReset;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  tun_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .va_i    (va),
    .vb_i    (vb),
    .vc_i    (vc),
    .valid_o (cr_v),
    .cross_o (cr)
  );

  tun_norm u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (cr_v),
    .cross_i   (cr),
    .min_len_i (min_len_q),
    .valid_o   (nm_v),
    .side_o    (nm_side),
    .sum_o     (nm_sum)
  );

  tun_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_v),
    .side_i  (nm_side),
    .rad_i   (nm_sum),
    .valid_o (sq_v),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  tun_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .side_i  (sq_side),
    .root_i  (sq_root),
    .valid_o (tail_v),
    .res_o   (tail_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= consume;
      end
    end else if (consume) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : tail_res;
    end else if (consume) begin
      skid_q <= tail_res;
    end
  end

  assign out_valid_o  = out_v_q;
  assign normal_x_o   = out_q.x;
  assign normal_y_o   = out_q.y;
  assign normal_z_o   = out_q.z;
  assign degenerate_o = out_q.degen;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a transaction while output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid filled without an output stall");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero normal");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o <= UnitMax && normal_x_o >= -UnitMax &&
                    normal_y_o <= UnitMax && normal_y_o >= -UnitMax &&
                    normal_z_o <= UnitMax && normal_z_o >= -UnitMax)
    else $error("normal component exceeds unit range");
`endif

endmodule
